// ===== rtl/crs_pkg.sv =====
`timescale 1ns / 1ps

package crs_pkg;

  localparam int unsigned LETTERS     = 26;
  localparam int unsigned LAST_LETTER = 25;
  localparam int unsigned LW          = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 60;

  typedef enum logic [1:0] {
    KIND_FWD     = 2'd0,
    KIND_BWD     = 2'd1,
    KIND_STEP    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIRING_LOW  = 3'd0,
    REG_WIRING_MID  = 3'd1,
    REG_WIRING_HIGH = 3'd2,
    REG_RING        = 3'd3,
    REG_START       = 3'd4,
    REG_NOTCH_A     = 3'd5,
    REG_NOTCH_B     = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [LW-1:0] letter_index;
  } in_t;

  typedef struct packed {
    logic [LW-1:0] mapped_index;
    logic [LW-1:0] position;
    logic          at_notch;
  } out_t;

  typedef struct packed {
    logic [LETTERS-1:0][LW-1:0] wiring;
    logic [LW-1:0]              ring;
    logic [LW-1:0]              start;
    logic [LW-1:0]              notch_a;
    logic [LW-1:0]              notch_b;
  } cfg_t;

  // five-bit value reduced mod 26
  function automatic logic [LW-1:0] red26(input logic [LW-1:0] v);
    logic [LW-1:0] r;
    r = (v >= LW'(LETTERS)) ? v - LW'(LETTERS) : v;
    return r;
  endfunction

  // (a + b - c) mod 26 for a, b, c in 0..25
  function automatic logic [LW-1:0] addsub26(input logic [LW-1:0] a,
                                             input logic [LW-1:0] b,
                                             input logic [LW-1:0] c);
    logic [6:0] s;
    logic [6:0] m;
    s = 7'(a) + 7'(b) + 7'(LETTERS) - 7'(c);
    if (s >= 7'(2 * LETTERS)) begin
      m = s - 7'(2 * LETTERS);
    end else if (s >= 7'(LETTERS)) begin
      m = s - 7'(LETTERS);
    end else begin
      m = s;
    end
    return m[LW-1:0];
  endfunction

endpackage

// ===== rtl/crs_cfg_regs.sv =====
`timescale 1ns / 1ps

module crs_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output crs_pkg::cfg_t                       cfg
);

  logic [59:0] wiring_low_r;
  logic [59:0] wiring_mid_r;
  logic [9:0]  wiring_high_r;
  logic [4:0]  ring_r;
  logic [4:0]  start_r;
  logic [4:0]  notch_a_r;
  logic [4:0]  notch_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiring_low_r  <= '0;
      wiring_mid_r  <= '0;
      wiring_high_r <= '0;
      ring_r        <= '0;
      start_r       <= '0;
      notch_a_r     <= '0;
      notch_b_r     <= '0;
    end else if (cfg_we) begin
      unique case (crs_pkg::reg_idx_t'(cfg_index))
        crs_pkg::REG_WIRING_LOW:  wiring_low_r  <= cfg_wdata[59:0];
        crs_pkg::REG_WIRING_MID:  wiring_mid_r  <= cfg_wdata[59:0];
        crs_pkg::REG_WIRING_HIGH: wiring_high_r <= cfg_wdata[9:0];
        crs_pkg::REG_RING:        ring_r        <= cfg_wdata[4:0];
        crs_pkg::REG_START:       start_r       <= cfg_wdata[4:0];
        crs_pkg::REG_NOTCH_A:     notch_a_r     <= cfg_wdata[4:0];
        crs_pkg::REG_NOTCH_B:     notch_b_r     <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // contact 0 sits in the lowest five bits
  assign cfg.wiring  = {wiring_high_r, wiring_mid_r, wiring_low_r};
  assign cfg.ring    = ring_r;
  assign cfg.start   = start_r;
  assign cfg.notch_a = notch_a_r;
  assign cfg.notch_b = notch_b_r;

endmodule

// ===== rtl/crs_map.sv =====
`timescale 1ns / 1ps

module crs_map (
  input  crs_pkg::in_t                 item,
  input  logic [crs_pkg::LW-1:0]       pos,
  input  crs_pkg::cfg_t                cfg,
  output crs_pkg::out_t                res
);

  logic [crs_pkg::LW-1:0] x;
  logic [crs_pkg::LW-1:0] r;
  logic [crs_pkg::LW-1:0] k;
  logic [crs_pkg::LW-1:0] fwd;
  logic [crs_pkg::LW-1:0] hit_j;
  logic                   hit;
  logic [crs_pkg::LW-1:0] mapped;
  logic [crs_pkg::LW-1:0] pos_nxt;

  assign x = crs_pkg::red26(item.letter_index);
  assign r = crs_pkg::red26(cfg.ring);
  // same shifted contact feeds both the forward lookup and the reverse compare
  assign k = crs_pkg::addsub26(x, pos, r);
  assign fwd = crs_pkg::addsub26(crs_pkg::red26(cfg.wiring[k]), r, pos);

  // lowest matching entry wins; entries above 25 never match
  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = crs_pkg::LETTERS - 1; j >= 0; j--) begin
      if (cfg.wiring[j] == k) begin
        hit   = 1'b1;
        hit_j = crs_pkg::LW'(j);
      end
    end
  end

  always_comb begin
    mapped  = '0;
    pos_nxt = pos;
    unique case (crs_pkg::kind_t'(item.kind))
      crs_pkg::KIND_FWD:     mapped = fwd;
      crs_pkg::KIND_BWD:     mapped = hit ? crs_pkg::addsub26(hit_j, r, pos) : '0;
      crs_pkg::KIND_STEP:    pos_nxt = (pos == crs_pkg::LW'(crs_pkg::LAST_LETTER)) ?
                                       '0 : pos + crs_pkg::LW'(1);
      crs_pkg::KIND_RESTART: pos_nxt = crs_pkg::red26(cfg.start);
      default: ;
    endcase
  end

  assign res.mapped_index = mapped;
  assign res.position     = pos_nxt;
  assign res.at_notch     = (pos_nxt == cfg.notch_a) || (pos_nxt == cfg.notch_b);

endmodule

// ===== rtl/cipher_rotor_stage_unit.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data  (kind, letter_index)
// out      output     out_valid / out_ready  out_data (mapped_index, position, at_notch)
// cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// One word per cycle sustained while out_ready stays high; a taken word waits in the
// input register and passes through the single map stage into the result register,
// which drives out_valid. The rotor position register sits beside the map stage
// and loads the new position as each word moves into the result register.
// rst_n (synchronous) clears the configuration registers, the position and both
// valid flags.
// A stalled output holds its word; the input register takes one more word and
// then holds in_ready low until the result register drains.

module cipher_rotor_stage_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  crs_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output crs_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  crs_pkg::cfg_t          cfg;
  crs_pkg::in_t           item_r;
  logic                   item_vld_r;
  crs_pkg::out_t          res_r;
  logic                   res_vld_r;
  crs_pkg::out_t          res_nxt;
  logic [crs_pkg::LW-1:0] pos_r;
  logic                   res_free;
  logic                   move;

  crs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crs_map u_map (
    .item (item_r),
    .pos  (pos_r),
    .cfg  (cfg),
    .res  (res_nxt)
  );

  assign res_free = !res_vld_r || out_ready;
  assign move     = item_vld_r && res_free;
  assign in_ready = !item_vld_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      pos_r      <= '0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (res_free) begin
        res_vld_r <= item_vld_r;
      end
      if (move) begin
        pos_r <= res_nxt.position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

// ===== rtl/crs_checker.sv =====
`timescale 1ns / 1ps

module crs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input crs_pkg::out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // reset leaves nothing on the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.position < 5'd26)
    else $error("position out of range");

  a_map_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mapped_index < 5'd26)
    else $error("mapped index out of range");

  // with the output draining, the input side never blocks
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && out_ready |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind cipher_rotor_stage_unit crs_checker u_crs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
